// ===== design/tdpt_pkg.sv =====
// Package for the trial-division prime test.
// Holds the status types shared by the sequencer and its arithmetic units.
package tdpt_pkg;

	// Status of the shared remainder unit, valid in the cycle of its last step.
	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

	// Status of the square-root unit.
	typedef struct packed {
		logic done;
	} sqrt_stat_t;

	// Smallest odd divisor that is ever tried.
	localparam int unsigned FIRST_DIVISOR = 3;

endpackage

// ===== design/tdpt_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on tdpt_pkg for the status type.
module tdpt_isqrt #(
	parameter int unsigned W = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [W-1:0]           value,
	output tdpt_pkg::sqrt_stat_t   stat,
	output logic [(W+1)/2-1:0]     root
);
	import tdpt_pkg::*;

	localparam int unsigned SW = (W + 1) / 2;
	localparam int unsigned CW = (SW > 1) ? $clog2(SW) : 1;

	logic              busy_q;
	logic [CW-1:0]     cnt_q;
	logic [2*SW-1:0]   val_q;
	logic [SW:0]       rem_q;
	logic [SW-1:0]     root_q;
	logic [SW+2:0]     rem_sh;
	logic [SW+2:0]     trial;
	logic              fits;
	logic [SW:0]       rem_next;
	logic [SW-1:0]     root_next;

	always_comb begin
		rem_sh    = {rem_q, val_q[2*SW-1 -: 2]};
		trial     = {1'b0, root_q, 2'b01};
		fits      = rem_sh >= trial;
		rem_next  = fits ? (SW+1)'(rem_sh - trial) : rem_sh[SW:0];
		root_next = {root_q[SW-2:0], fits};
	end

	assign stat.done = busy_q && (cnt_q == '0);
	assign root      = root_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(SW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= (2*SW)'(value);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[2*SW-3:0], 2'b00};
			rem_q  <= rem_next;
			root_q <= root_next;
		end
	end

endmodule

// ===== design/tdpt_rem.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on tdpt_pkg for the status type.
module tdpt_rem #(
	parameter int unsigned W  = 32,
	parameter int unsigned DW = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          dividend,
	input  logic [DW-1:0]         divisor,
	output tdpt_pkg::rem_stat_t   stat
);
	import tdpt_pkg::*;

	localparam int unsigned CW = $clog2(W);

	logic            busy_q;
	logic [CW-1:0]   cnt_q;
	logic [W-1:0]    num_q;
	logic [DW-1:0]   div_q;
	logic [DW-1:0]   rem_q;
	logic [DW:0]     rem_sh;
	logic [DW-1:0]   rem_next;

	always_comb begin
		rem_sh   = {rem_q, num_q[W-1]};
		rem_next = (rem_sh >= {1'b0, div_q}) ? DW'(rem_sh - {1'b0, div_q}) : rem_sh[DW-1:0];
	end

	assign stat.done = busy_q && (cnt_q == '0);
	assign stat.zero = rem_next == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

endmodule

// ===== design/trial_division_prime_test.sv =====
// Top level of the trial-division prime test: sequencer over a square-root unit
// and one shared remainder unit. Depends on tdpt_pkg, tdpt_isqrt and tdpt_rem.
//
// Channel   Ports                    Transfer
// input     start, busy, number      rising edge with start high and busy low
// result    done, is_prime           rising edge that ends the one-cycle done strobe
//
// Zero, one, two and even numbers raise done in the cycle after the transfer.
// An odd number above one first takes its square root, then checks the root
// against the first divisor, then runs the remainder unit once for each odd
// divisor tried, up to the root.
// Reset clears the sequencer and the strobe; busy stays high until the result.
// The receiver cannot stall, so done always lasts exactly one cycle.
module trial_division_prime_test #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [VALUE_WIDTH-1:0]  number,
	output logic                    done,
	output logic                    is_prime
);
	import tdpt_pkg::*;

	localparam int unsigned SW = (VALUE_WIDTH + 1) / 2;
	localparam int unsigned DW = SW + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SQRT  = 2'd1;
	localparam logic [1:0] ST_FIRST = 2'd2;
	localparam logic [1:0] ST_TRIAL = 2'd3;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] n_q;
	logic [SW-1:0]          r_q;
	logic [DW-1:0]          d_q;
	logic                   done_q;
	logic                   prime_q;

	sqrt_stat_t             sqrt_stat;
	rem_stat_t              rem_stat;
	logic [SW-1:0]          root;
	logic                   sqrt_start;
	logic                   rem_start;
	logic [DW-1:0]          d_next;
	logic [DW-1:0]          d_load;
	logic                   accept;

	assign accept     = start && (state_q == ST_IDLE);
	assign sqrt_start = accept && number[0] && (number != VALUE_WIDTH'(1));
	assign d_next     = d_q + DW'(2);

	always_comb begin
		rem_start = 1'b0;
		d_load    = DW'(FIRST_DIVISOR);
		unique case (state_q)
			ST_FIRST: begin
				rem_start = {1'b0, r_q} >= DW'(FIRST_DIVISOR);
			end
			ST_TRIAL: begin
				rem_start = rem_stat.done && !rem_stat.zero && (d_next <= {1'b0, r_q});
				d_load    = d_next;
			end
			default: begin
				rem_start = 1'b0;
			end
		endcase
	end

	tdpt_isqrt #(.W(VALUE_WIDTH)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (number),
		.stat   (sqrt_stat),
		.root   (root)
	);

	tdpt_rem #(.W(VALUE_WIDTH), .DW(DW)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (n_q),
		.divisor  (d_load),
		.stat     (rem_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			prime_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sqrt_start) begin
							state_q <= ST_SQRT;
						end else begin
							done_q  <= 1'b1;
							prime_q <= number == VALUE_WIDTH'(2);
						end
					end
				end
				ST_SQRT: begin
					if (sqrt_stat.done) begin
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					if (!rem_start) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						prime_q <= 1'b1;
					end else begin
						state_q <= ST_TRIAL;
					end
				end
				ST_TRIAL: begin
					if (rem_stat.done && !rem_start) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						prime_q <= !rem_stat.zero;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= number;
		end
		if (sqrt_stat.done) begin
			r_q <= root;
		end
		if (rem_start) begin
			d_q <= d_load;
		end
	end

	assign busy     = state_q != ST_IDLE;
	assign done     = done_q;
	assign is_prime = prime_q;

	a_fall_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result strobe");

	a_small_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (number < VALUE_WIDTH'(2))) |=> (done && !is_prime))
		else $error("zero or one not reported as composite");

	a_divisor_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRIAL) |-> (d_q[0] && (d_q <= {1'b0, r_q})))
		else $error("trial divisor out of range or even");

endmodule
